[rtl/core/fvn_pkg.sv]
// Shared types, constants and hash helpers for the fractal value noise block.
`timescale 1ns / 1ps
package fvn_pkg;

  // Default octave count and the largest count that the accumulator widths cover
  localparam int unsigned MAX_OCTAVES_DEF = 8;
  localparam int unsigned OCT_LIMIT       = 16;

  // Accumulator: each octave term stays below 2^32 in magnitude
  localparam int ACC_W   = 33 + $clog2(OCT_LIMIT);
  localparam int WSUM_W  = 16 + $clog2(OCT_LIMIT);
  localparam int PROD_W  = ACC_W + 16;
  localparam int MAG_W   = PROD_W - 1;
  localparam int DVS_W   = WSUM_W + 16;
  localparam int QUO_W   = 18;
  localparam int NOISE_W = 17;

  localparam logic [15:0] OUT_MAG = 16'hFFFF;

  localparam logic [31:0] LCG_MUL      = 32'd1664525;
  localparam logic [31:0] LCG_ADD      = 32'd1013904223;
  localparam logic [31:0] GOLD_LO      = 32'h85EBCA87;
  localparam logic [31:0] GOLD_HI      = 32'h9E3779B1;
  localparam logic [31:0] MIX_MUL1     = 32'h7FEB352D;
  localparam logic [31:0] MIX_MUL2     = 32'h846CA68B;
  localparam logic [31:0] CORNER_SCALE = 32'd1000;
  localparam logic [17:0] SMOOTH_K     = 18'd196608;

  localparam logic [31:0] RST_BASE_FREQ   = 32'd83886;
  localparam logic [15:0] RST_AMPLITUDE   = 16'd15360;
  localparam logic [3:0]  RST_OCT_COUNT   = 4'd4;
  localparam logic [15:0] RST_PERSISTENCE = 16'd32768;
  localparam logic [15:0] RST_LACUNARITY  = 16'd8192;

  typedef enum logic [2:0] {
    REG_BASE_FREQ    = 3'd0,
    REG_AMPLITUDE    = 3'd1,
    REG_OCTAVE_COUNT = 3'd2,
    REG_PERSISTENCE  = 3'd3,
    REG_LACUNARITY   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] base_frequency;
    logic [15:0] amplitude;
    logic [3:0]  octave_count;
    logic [15:0] persistence;
    logic [15:0] lacunarity;
  } cfg_t;

  // Data handed from one octave cell to the next
  typedef struct packed {
    logic                     valid;
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic [31:0]              seed;
    logic [31:0]              freq;
    logic [15:0]              weight;
    logic signed [ACC_W-1:0]  acc;
    logic [WSUM_W-1:0]        wsum;
  } carry_t;

  // Data handed from one divider step to the next
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              zero;
    logic [MAG_W-1:0]  rem;
    logic [DVS_W-1:0]  dvs;
    logic [QUO_W-1:0]  quo;
  } div_t;

  function automatic logic [31:0] lcg(input logic [31:0] h);
    lcg = h * LCG_MUL + LCG_ADD;
  endfunction

  // floor(f*f*(3*65536 - 2*f) / 2^32)
  function automatic logic [15:0] smooth(input logic [15:0] f, input logic [31:0] ff);
    logic [17:0] k;
    logic [49:0] p;
    k = SMOOTH_K - {1'b0, f, 1'b0};
    p = 50'(ff) * 50'(k);
    smooth = p[47:32];
  endfunction

endpackage

[rtl/core/fractal_value_noise_2d.sv]
// Fractal value noise top level: octave cell chain, normalizing divider, output skid.
// Throughput: one transaction per cycle while the skid has room; every octave cell and divider step is fully pipelined.
// The whole pipe advances while the two-entry output skid has room.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
module fractal_value_noise_2d #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  in_pos_x,
  input  logic signed [31:0]                  in_pos_y,
  input  logic signed [31:0]                  in_seed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fvn_pkg::NOISE_W-1:0]  out_noise_value,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_wdata
);

  fvn_pkg::cfg_t   cfg_r, cfg_nxt;
  fvn_pkg::carry_t chain [MAX_OCTAVES+1];
  fvn_pkg::div_t   dv [fvn_pkg::QUO_W+1];
  fvn_pkg::div_t   b_r, b_nxt;

  logic                               en;
  logic                               a_valid_r;
  logic signed [fvn_pkg::PROD_W-1:0]  a_prod_r;
  logic [fvn_pkg::WSUM_W-1:0]         a_wsum_r;
  logic signed [fvn_pkg::PROD_W-1:0]  a_neg;

  logic [1:0]                         cnt_r, cnt_nxt;
  logic signed [fvn_pkg::NOISE_W-1:0] skid0_r, skid1_r, skid0_nxt, skid1_nxt;
  logic signed [fvn_pkg::NOISE_W-1:0] res;
  logic [fvn_pkg::QUO_W:0]            neg_t;
  logic                               push, pop;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (fvn_pkg::cfg_reg_t'(cfg_index))
        fvn_pkg::REG_BASE_FREQ:    cfg_nxt.base_frequency = cfg_wdata;
        fvn_pkg::REG_AMPLITUDE:    cfg_nxt.amplitude      = cfg_wdata[15:0];
        fvn_pkg::REG_OCTAVE_COUNT: cfg_nxt.octave_count   = cfg_wdata[3:0];
        fvn_pkg::REG_PERSISTENCE:  cfg_nxt.persistence    = cfg_wdata[15:0];
        fvn_pkg::REG_LACUNARITY:   cfg_nxt.lacunarity     = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_frequency <= fvn_pkg::RST_BASE_FREQ;
      cfg_r.amplitude      <= fvn_pkg::RST_AMPLITUDE;
      cfg_r.octave_count   <= fvn_pkg::RST_OCT_COUNT;
      cfg_r.persistence    <= fvn_pkg::RST_PERSISTENCE;
      cfg_r.lacunarity     <= fvn_pkg::RST_LACUNARITY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Advance the pipe while the skid can still take one more result
  assign en       = cnt_r != 2'd2;
  assign in_ready = en;

  always_comb begin
    chain[0].valid  = in_valid && en;
    chain[0].pos_x  = in_pos_x;
    chain[0].pos_y  = in_pos_y;
    chain[0].seed   = in_seed;
    chain[0].freq   = cfg_r.base_frequency;
    chain[0].weight = cfg_r.amplitude;
    chain[0].acc    = '0;
    chain[0].wsum   = '0;
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fvn_octave_cell #(
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .cfg   (cfg_r),
      .c_i   (chain[i]),
      .c_o   (chain[i+1])
    );
  end

  // Numerator times amplitude, then sign and magnitude for the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_r.valid <= 1'b0;
    end else if (en) begin
      a_valid_r <= chain[MAX_OCTAVES].valid;
      b_r       <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= chain[MAX_OCTAVES].acc * $signed({1'b0, cfg_r.amplitude});
      a_wsum_r <= chain[MAX_OCTAVES].wsum;
    end
  end

  assign a_neg = -a_prod_r;

  always_comb begin
    b_nxt.valid = a_valid_r;
    b_nxt.neg   = a_prod_r[fvn_pkg::PROD_W-1];
    b_nxt.zero  = a_wsum_r == '0;
    b_nxt.rem   = b_nxt.neg ? a_neg[fvn_pkg::MAG_W-1:0] : a_prod_r[fvn_pkg::MAG_W-1:0];
    b_nxt.dvs   = fvn_pkg::DVS_W'(a_wsum_r);
    b_nxt.quo   = '0;
  end

  assign dv[0] = b_r;

  for (genvar k = 0; k < fvn_pkg::QUO_W; k++) begin : g_div
    fvn_div_step #(
      .SHIFT (fvn_pkg::QUO_W - 1 - k)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (dv[k]),
      .d_o   (dv[k+1])
    );
  end

  // Floor toward minus infinity for negative sums, then clamp
  assign neg_t = (fvn_pkg::QUO_W + 1)'(dv[fvn_pkg::QUO_W].quo)
               + (fvn_pkg::QUO_W + 1)'(|dv[fvn_pkg::QUO_W].rem);

  always_comb begin
    if (dv[fvn_pkg::QUO_W].zero) begin
      res = '0;
    end else if (!dv[fvn_pkg::QUO_W].neg) begin
      if (dv[fvn_pkg::QUO_W].quo > fvn_pkg::QUO_W'(fvn_pkg::OUT_MAG)) begin
        res = $signed({1'b0, fvn_pkg::OUT_MAG});
      end else begin
        res = $signed({1'b0, dv[fvn_pkg::QUO_W].quo[15:0]});
      end
    end else begin
      if (neg_t > (fvn_pkg::QUO_W + 1)'(fvn_pkg::OUT_MAG)) begin
        res = -$signed({1'b0, fvn_pkg::OUT_MAG});
      end else begin
        res = -$signed({1'b0, neg_t[15:0]});
      end
    end
  end

  // Two-entry output skid
  assign push = en && dv[fvn_pkg::QUO_W].valid;
  assign pop  = out_valid && out_ready;

  always_comb begin
    skid0_nxt = skid0_r;
    skid1_nxt = skid1_r;
    if (pop) begin
      skid0_nxt = skid1_r;
    end
    if (push) begin
      if ((cnt_r - 2'(pop)) == 2'd0) begin
        skid0_nxt = res;
      end else begin
        skid1_nxt = res;
      end
    end
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    skid0_r <= skid0_nxt;
    skid1_r <= skid1_nxt;
  end

  assign out_valid       = cnt_r != 2'd0;
  assign out_noise_value = skid0_r;

  a_skid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output skid overfilled");

  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_noise_value != {1'b1, 16'h0000})
    else $error("noise value outside clamp range");

endmodule

[rtl/core/fvn_octave_cell.sv]
// One octave of value noise: split, smoothstep, corner hashes, lerps and weighting.
`timescale 1ns / 1ps
module fvn_octave_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fvn_pkg::cfg_t   cfg,
  input  fvn_pkg::carry_t c_i,
  output fvn_pkg::carry_t c_o
);

  localparam int LINE_LEN = 14;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
  } smooth_t;

  fvn_pkg::carry_t    line_r [LINE_LEN];
  fvn_pkg::carry_t    out_r;
  fvn_pkg::carry_t    out_nxt;

  logic signed [63:0] px_prod_r, py_prod_r;
  logic [31:0]        hx0_r, hx1_r, hy0_r, hy1_r;
  logic [15:0]        fx_r, fy_r;
  logic [31:0]        ffx_r, ffy_r;
  logic [31:0]        lx_r [2];
  logic [31:0]        hy3_r [2];
  smooth_t            sm_r [9];
  logic [31:0]        h4_r [4];
  logic [63:0]        glo4_r;
  logic [31:0]        ghi4_r;
  logic [31:0]        h5_r [4];
  logic [31:0]        gold5_r;
  logic [31:0]        h6_r [4];
  logic [31:0]        h7_r [4];
  logic [31:0]        h8_r [4];
  logic signed [17:0] v9_r [4];
  logic signed [17:0] v9_nxt [4];
  logic signed [34:0] p0_r, p1_r;
  logic signed [17:0] a0_r, a1_r;
  logic signed [17:0] n0_r, n1_r;
  logic signed [34:0] q_r;
  logic signed [17:0] n0b_r;
  logic signed [17:0] n_r;
  logic signed [34:0] term_r;
  logic [47:0]        fprod_r;
  logic [31:0]        wprod_r;
  logic               active;

  assign active = 4'(IDX) < cfg.octave_count;

  always_comb begin
    logic [31:0] hf;
    for (int c = 0; c < 4; c++) begin
      hf = h8_r[c] ^ (h8_r[c] >> 16);
      v9_nxt[c] = $signed({1'b0, hf[31:15]}) - 18'sd65536;
    end
  end

  // Valid travels with the carry line; payload registers hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LINE_LEN; k++) begin
        line_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      line_r[0] <= c_i;
      for (int k = 1; k < LINE_LEN; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // split position into cell and fraction
      px_prod_r <= $signed(c_i.pos_x) * $signed({1'b0, c_i.freq});
      py_prod_r <= $signed(c_i.pos_y) * $signed({1'b0, c_i.freq});

      hx0_r <= px_prod_r[63:32] * fvn_pkg::CORNER_SCALE;
      hx1_r <= px_prod_r[63:32] * fvn_pkg::CORNER_SCALE + fvn_pkg::CORNER_SCALE;
      hy0_r <= py_prod_r[63:32] * fvn_pkg::CORNER_SCALE;
      hy1_r <= py_prod_r[63:32] * fvn_pkg::CORNER_SCALE + fvn_pkg::CORNER_SCALE;
      fx_r  <= px_prod_r[31:16];
      fy_r  <= py_prod_r[31:16];
      ffx_r <= px_prod_r[31:16] * px_prod_r[31:16];
      ffy_r <= py_prod_r[31:16] * py_prod_r[31:16];

      lx_r[0]  <= fvn_pkg::lcg(hx0_r);
      lx_r[1]  <= fvn_pkg::lcg(hx1_r);
      hy3_r[0] <= hy0_r;
      hy3_r[1] <= hy1_r;
      sm_r[0].sx <= fvn_pkg::smooth(fx_r, ffx_r);
      sm_r[0].sy <= fvn_pkg::smooth(fy_r, ffy_r);
      for (int k = 1; k < 9; k++) begin
        sm_r[k] <= sm_r[k-1];
      end

      // corner c: bit 0 picks x neighbor, bit 1 picks y neighbor
      for (int c = 0; c < 4; c++) begin
        h4_r[c] <= fvn_pkg::lcg(lx_r[c % 2] ^ hy3_r[c / 2]);
      end
      glo4_r <= line_r[2].seed * fvn_pkg::GOLD_LO;
      ghi4_r <= line_r[2].seed * fvn_pkg::GOLD_HI;

      for (int c = 0; c < 4; c++) begin
        h5_r[c] <= fvn_pkg::lcg(h4_r[c] ^ line_r[3].seed);
      end
      gold5_r <= glo4_r[63:32] + ghi4_r;

      for (int c = 0; c < 4; c++) begin
        h6_r[c] <= fvn_pkg::lcg(h5_r[c] ^ gold5_r);
        h7_r[c] <= (h6_r[c] ^ (h6_r[c] >> 16)) * fvn_pkg::MIX_MUL1;
        h8_r[c] <= (h7_r[c] ^ (h7_r[c] >> 15)) * fvn_pkg::MIX_MUL2;
        v9_r[c] <= v9_nxt[c];
      end

      // lerp along x, then along y
      p0_r <= (v9_r[1] - v9_r[0]) * $signed({1'b0, sm_r[6].sx});
      p1_r <= (v9_r[3] - v9_r[2]) * $signed({1'b0, sm_r[6].sx});
      a0_r <= v9_r[0];
      a1_r <= v9_r[2];

      n0_r <= a0_r + $signed(p0_r[33:16]);
      n1_r <= a1_r + $signed(p1_r[33:16]);

      q_r   <= (n1_r - n0_r) * $signed({1'b0, sm_r[8].sy});
      n0b_r <= n0_r;

      n_r <= n0b_r + $signed(q_r[33:16]);

      term_r  <= n_r * $signed({1'b0, line_r[12].weight});
      fprod_r <= line_r[12].freq * cfg.lacunarity;
      wprod_r <= line_r[12].weight * cfg.persistence;
    end
  end

  always_comb begin
    out_nxt        = line_r[LINE_LEN-1];
    out_nxt.seed   = line_r[LINE_LEN-1].seed + 32'd1;
    out_nxt.freq   = (|fprod_r[47:44]) ? '1 : fprod_r[43:12];
    out_nxt.weight = wprod_r[31:16];
    if (active) begin
      out_nxt.acc  = line_r[LINE_LEN-1].acc + fvn_pkg::ACC_W'(term_r);
      out_nxt.wsum = line_r[LINE_LEN-1].wsum + fvn_pkg::WSUM_W'(line_r[LINE_LEN-1].weight);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

  assign c_o = out_r;

endmodule

[rtl/core/fvn_div_step.sv]
// One restoring step of the normalizing divider: compare, subtract, set a quotient bit.
`timescale 1ns / 1ps
module fvn_div_step #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  fvn_pkg::div_t d_i,
  output fvn_pkg::div_t d_o
);

  fvn_pkg::div_t           d_r;
  fvn_pkg::div_t           d_nxt;
  logic [fvn_pkg::MAG_W:0] dsh;
  logic                    ge;

  // divisor is weight sum times 65536, aligned to this quotient bit
  assign dsh = (fvn_pkg::MAG_W + 1)'({d_i.dvs, 16'h0000}) << SHIFT;
  assign ge  = {1'b0, d_i.rem} >= dsh;

  always_comb begin
    d_nxt = d_i;
    if (ge) begin
      d_nxt.rem = d_i.rem - dsh[fvn_pkg::MAG_W-1:0];
      d_nxt.quo = d_i.quo | (fvn_pkg::QUO_W'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

[tb/tb_fractal_value_noise_2d.sv]
// Testbench for the fractal value noise block: directed and random positions across settings.
`timescale 1ns / 1ps
module tb_fractal_value_noise_2d;

  localparam int OCT_MAX = 8;
  localparam int PIPE_LAT = 15 * OCT_MAX + 21;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_seed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [16:0] out_noise_value;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // shadow copy of the block's settings
  logic [31:0] m_freq;
  logic [15:0] m_amp;
  logic [3:0] m_count;
  logic [15:0] m_pers;
  logic [15:0] m_lac;

  logic signed [16:0] noise_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  longint cycles = 0;
  bit stall_enable = 1'b1;

  fractal_value_noise_2d DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] hash_corner(logic [31:0] cx, logic [31:0] cy,
                                              logic [31:0] sd);
    logic [31:0] h, gold;
    logic [95:0] wide;
    wide = {64'd0, sd} * 96'h9E3779B185EBCA87;
    gold = wide[63:32];
    h = cx * 32'd1000;
    h = h * 32'd1664525 + 32'd1013904223;
    h ^= cy * 32'd1000;
    h = h * 32'd1664525 + 32'd1013904223;
    h ^= sd;
    h = h * 32'd1664525 + 32'd1013904223;
    h ^= gold;
    h = h * 32'd1664525 + 32'd1013904223;
    h ^= h >> 16;
    h *= 32'h7feb352d;
    h ^= h >> 15;
    h *= 32'h846ca68b;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic longint corner_val(logic [31:0] cx, logic [31:0] cy, logic [31:0] sd);
    return longint'(hash_corner(cx, cy, sd) >> 15) - 65536;
  endfunction

  function automatic longint blend(longint a, longint b, longint s);
    return a + ((b - a) * s >>> 16);
  endfunction

  function automatic longint ease(longint f);
    return (f * f * (196608 - 2 * f)) >> 32;
  endfunction

  function automatic longint octave_sample(logic signed [31:0] px, logic signed [31:0] py,
                                           logic [31:0] freq, logic [31:0] sd);
    logic [63:0] sx, sy;
    logic [31:0] x0, y0;
    longint ex, ey, a, b;
    sx = 64'($signed(64'(px)) * $signed({32'd0, freq}));
    sy = 64'($signed(64'(py)) * $signed({32'd0, freq}));
    x0 = sx[63:32];
    y0 = sy[63:32];
    ex = ease(longint'(sx[31:16]));
    ey = ease(longint'(sy[31:16]));
    a = blend(corner_val(x0, y0, sd), corner_val(x0 + 1, y0, sd), ex);
    b = blend(corner_val(x0, y0 + 1, sd), corner_val(x0 + 1, y0 + 1, sd), ex);
    return blend(a, b, ey);
  endfunction

  function automatic logic signed [16:0] fractal_noise(logic signed [31:0] px,
                                                       logic signed [31:0] py,
                                                       logic [31:0] sd);
    int cnt;
    longint freq, w, acc, wsum, num, den, q;
    cnt = (m_count > OCT_MAX) ? OCT_MAX : m_count;
    freq = m_freq;
    w = m_amp;
    acc = 0;
    wsum = 0;
    for (int i = 0; i < cnt; i++) begin
      acc += octave_sample(px, py, freq[31:0], sd + i) * w;
      wsum += w;
      w = (w * m_pers) >> 16;
      freq = (freq * m_lac) >> 12;
      if (freq > 64'hFFFFFFFF) freq = 64'hFFFFFFFF;
    end
    if (wsum == 0) return '0;
    num = acc * m_amp;
    den = wsum * 65536;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    if (q > 65535) q = 65535;
    if (q < -65535) q = -65535;
    return q[16:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [16:0] got,
                                 logic signed [16:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // result side: random stalls, compare each transaction in order
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_seen++;
      if (noise_q.size() == 0) report_mismatch("unexpected result", out_noise_value, 'x);
      else begin
        logic signed [16:0] want;
        want = noise_q.pop_front();
        if (out_noise_value !== want) report_mismatch("noise_value", out_noise_value, want);
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        hold = gap_len();
        out_ready <= (hold == 0);
      end else out_ready <= 1'b1;
    end
  end

  task automatic send_sample(logic signed [31:0] px, logic signed [31:0] py,
                             logic [31:0] sd);
    int g;
    g = stall_enable ? gap_len() : 0;
    // drop valid only for a real gap so back-to-back transactions keep it high
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_seed <= sd;
    noise_q.push_back(fractal_noise(px, py, sd));
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic write_reg(fvn_pkg::cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      fvn_pkg::REG_BASE_FREQ:    m_freq = val;
      fvn_pkg::REG_AMPLITUDE:    m_amp = val[15:0];
      fvn_pkg::REG_OCTAVE_COUNT: m_count = val[3:0];
      fvn_pkg::REG_PERSISTENCE:  m_pers = val[15:0];
      fvn_pkg::REG_LACUNARITY:   m_lac = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] f, logic [15:0] a, logic [3:0] c,
                           logic [15:0] p, logic [15:0] l);
    drain();
    write_reg(fvn_pkg::REG_BASE_FREQ, f);
    write_reg(fvn_pkg::REG_AMPLITUDE, {16'd0, a});
    write_reg(fvn_pkg::REG_OCTAVE_COUNT, {28'd0, c});
    write_reg(fvn_pkg::REG_PERSISTENCE, {16'd0, p});
    write_reg(fvn_pkg::REG_LACUNARITY, {16'd0, l});
  endtask

  task automatic test_directed();
    send_sample(0, 0, 0);
    send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hFFFFFFFF);
    send_sample(32'sh80000000, 32'sh80000000, 32'h80000000);
    send_sample(32'sh80000000, 32'sh7FFFFFFF, 32'h7FFFFFFF);
    send_sample(-1, 1, 32'hFFFFFFF9);
    send_sample(256, -256, 1);
    send_sample(32'h12345678, 32'hEDCBA987, 32'hDEADBEEF);
    // huge frequency: cell coordinates wrap, neighbor cell wraps
    configure(32'hFFFFFFFF, 16'hFFFF, 4'd8, 16'hFFFF, 16'hFFFF);
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'h0);
    send_sample(32'sh80000000, -1, 32'h55555555);
    send_sample(32'h00ABCDEF, 32'hFF012345, 32'hAAAAAAAA);
    // count above the octave limit saturates
    configure(32'h01000000, 16'h0100, 4'd15, 16'h8000, 16'h2000);
    send_sample(12345, -6789, 42);
    send_sample(-12345, 6789, 32'hFFFFFFFF);
    // zero octaves and zero amplitude give zero
    configure(32'h01000000, 16'h0100, 4'd0, 16'h8000, 16'h2000);
    send_sample(1000, 2000, 3);
    configure(32'h01000000, 16'h0000, 4'd3, 16'h8000, 16'h2000);
    send_sample(1000, 2000, 3);
    // zero frequency, persistence and lacunarity
    configure(32'h0, 16'h0001, 4'd1, 16'h0, 16'h0);
    send_sample(32'sh7FFFFFFF, 32'sh80000000, 5);
    send_sample(777, -777, 32'h80000001);
  endtask

  task automatic test_random(int n);
    logic [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = $urandom();
      y = $urandom();
      if ($urandom_range(0, 2) != 0) begin
        x = {{16{x[31]}}, x[15:0]};
        y = {{16{y[31]}}, y[15:0]};
      end
      send_sample(x, y, $urandom());
    end
  endtask

  task automatic test_settings();
    for (int ph = 0; ph < 6; ph++) begin
      configure($urandom() >> $urandom_range(0, 31), 16'($urandom()),
                4'($urandom_range(0, 15)), 16'($urandom()), 16'($urandom()));
      stall_enable = (ph != 2);
      test_random(250);
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    m_freq = 32'd83886;
    m_amp = 16'd15360;
    m_count = 4'd4;
    m_pers = 16'd32768;
    m_lac = 16'd8192;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_random(100);
    test_directed();
    configure(32'd83886, 16'd15360, 4'd4, 16'd32768, 16'd8192);
    test_random(150);
    test_settings();
    drain();
    $display("sent %0d positions, checked %0d noise values over several register settings",
             n_sent, n_seen);
    if (errors == 0 && noise_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
